[sv/snpm_pkg.sv]
package snpm_pkg;

   // default sizes of the ring and of the challenge
   localparam int RING_DEGREE_DEF      = 512;
   localparam int CHALLENGE_WEIGHT_DEF = 19;

   // field widths of the streams
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 5;
   localparam int POS_W   = 9;
   localparam int INDEX_W = 9;
   localparam int COEFF_W = 24;
   localparam int VALUE_W = 29;

   // packed tdata widths, whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // saturation bounds of the result coefficient
   localparam int VAL_MAX = 268435455;
   localparam int VAL_MIN = -268435456;

   // operation codes carried on req_tuser
   localparam logic [OP_W-1:0] OP_WRITE_POS   = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_COEFF = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic accept;   // input word taken this cycle
      logic start;    // compute word taken: clear accumulator and term counter
      logic issue;    // read the next challenge term
      logic finish;   // load the saturated sum into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_term;  // counter sits on the last challenge slot
      logic pipe_busy;  // terms still in flight toward the accumulator
      logic out_busy;   // output register holds a word that is not taken now
   } sts_type;

endpackage

[sv/snpm_controller.sv]
module snpm_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic [snpm_pkg::OP_W-1:0]   req_op,
   input  snpm_pkg::sts_type           sts,
   output logic                        req_tready,
   output snpm_pkg::cmd_type           cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && (req_op == snpm_pkg::OP_COMPUTE)) begin
               cmd.start = 1'b1;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (sts.last_term) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last term and for room in the output register
            if (!sts.pipe_busy && !sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/snpm_datapath.sv]
module snpm_datapath #(
   parameter int RING_DEGREE      = snpm_pkg::RING_DEGREE_DEF,
   parameter int CHALLENGE_WEIGHT = snpm_pkg::CHALLENGE_WEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  snpm_pkg::cmd_type                   cmd,
   input  logic [snpm_pkg::OP_W-1:0]           req_op,
   input  logic [snpm_pkg::SLOT_W-1:0]         req_slot,
   input  logic [snpm_pkg::POS_W-1:0]          req_position,
   input  logic [snpm_pkg::INDEX_W-1:0]        req_coeff_index,
   input  logic signed [snpm_pkg::COEFF_W-1:0] req_coeff_value,
   input  logic                                rsp_tready,
   output snpm_pkg::sts_type                   sts,
   output logic                                rsp_tvalid,
   output logic [snpm_pkg::INDEX_W-1:0]        rsp_index,
   output logic signed [snpm_pkg::VALUE_W-1:0] rsp_value
);

   localparam int IDX_W   = $clog2(RING_DEGREE);
   localparam int TERM_W  = (CHALLENGE_WEIGHT > 1) ? $clog2(CHALLENGE_WEIGHT) : 1;
   // wide enough for any 9-bit field, the ring degree and k + N
   localparam int EXT_W   = IDX_W + 11;
   localparam int SEXT_W  = TERM_W + 7;
   localparam int ACC_W   = snpm_pkg::COEFF_W + $clog2(CHALLENGE_WEIGHT) + 1;
   localparam int SAT_W   = ACC_W + snpm_pkg::VALUE_W;
   localparam logic [EXT_W-1:0]         N_EXT   = EXT_W'(RING_DEGREE);
   localparam logic [SEXT_W-1:0]        W_EXT   = SEXT_W'(CHALLENGE_WEIGHT);
   localparam logic [TERM_W-1:0]        LAST    = TERM_W'(CHALLENGE_WEIGHT - 1);
   localparam logic signed [SAT_W-1:0]  SAT_MAX = SAT_W'(snpm_pkg::VAL_MAX);
   localparam logic signed [SAT_W-1:0]  SAT_MIN = SAT_W'(snpm_pkg::VAL_MIN);

   // stores
   logic [snpm_pkg::POS_W-1:0]          pos_mem   [CHALLENGE_WEIGHT];
   logic signed [snpm_pkg::COEFF_W-1:0] dense_mem [RING_DEGREE];

   logic [SEXT_W-1:0] slot_ext;
   logic [EXT_W-1:0]  widx_ext;
   logic              pos_we;
   logic              dense_we;

   // compute context
   logic [snpm_pkg::INDEX_W-1:0] k_ff;
   logic                         k_ok_ff;
   logic [TERM_W-1:0]            cnt_ff;

   // stage 1: position read back
   logic                       s1_vld_ff;
   logic [snpm_pkg::POS_W-1:0] s1_pos_ff;
   logic [EXT_W-1:0]           k_ext;
   logic [EXT_W-1:0]           p_ext;
   logic [EXT_W-1:0]           addr_ext;
   logic                       s1_use;
   logic                       s1_sub;

   // stage 2: dense read back
   logic                                s2_vld_ff;
   logic                                s2_use_ff;
   logic                                s2_sub_ff;
   logic signed [snpm_pkg::COEFF_W-1:0] s2_coeff_ff;

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] term;
   logic signed [SAT_W-1:0] acc_wide;
   logic signed [snpm_pkg::VALUE_W-1:0] sat_value;

   logic                                rsp_valid_ff;
   logic [snpm_pkg::INDEX_W-1:0]        rsp_index_ff;
   logic signed [snpm_pkg::VALUE_W-1:0] rsp_value_ff;

   // load decode
   assign slot_ext = {{(SEXT_W - snpm_pkg::SLOT_W){1'b0}}, req_slot};
   assign widx_ext = {{(EXT_W - snpm_pkg::INDEX_W){1'b0}}, req_coeff_index};
   assign pos_we   = cmd.accept && (req_op == snpm_pkg::OP_WRITE_POS) && (slot_ext < W_EXT);
   assign dense_we = cmd.accept && (req_op == snpm_pkg::OP_WRITE_COEFF) &&
                     (widx_ext < N_EXT);

   // challenge position store, read at the term counter
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[slot_ext[TERM_W-1:0]] <= req_position;
      end
      s1_pos_ff <= pos_mem[cnt_ff];
   end

   // compute context and term counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start) begin
         cnt_ff <= '0;
      end else if (cmd.issue && (cnt_ff != LAST)) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.start) begin
         k_ff    <= req_coeff_index;
         k_ok_ff <= widx_ext < N_EXT;
      end
   end

   // negacyclic address: k - p, wrapped by +N with a sign flip
   assign k_ext    = {{(EXT_W - snpm_pkg::INDEX_W){1'b0}}, k_ff};
   assign p_ext    = {{(EXT_W - snpm_pkg::POS_W){1'b0}}, s1_pos_ff};
   assign s1_sub   = k_ext >= p_ext;
   assign s1_use   = k_ok_ff && (p_ext < N_EXT);
   assign addr_ext = s1_sub ? (k_ext - p_ext) : (k_ext + N_EXT - p_ext);

   // dense store, one read per term
   always_ff @(posedge clock) begin
      if (dense_we) begin
         dense_mem[widx_ext[IDX_W-1:0]] <= req_coeff_value;
      end
      s2_coeff_ff <= dense_mem[addr_ext[IDX_W-1:0]];
      s2_use_ff   <= s1_use;
      s2_sub_ff   <= s1_sub;
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // accumulate: subtract for k >= p, add for a wrapped term
   assign term = {{(ACC_W - snpm_pkg::COEFF_W){s2_coeff_ff[snpm_pkg::COEFF_W-1]}}, s2_coeff_ff};
   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (s2_vld_ff && s2_use_ff) begin
         acc_in = s2_sub_ff ? (acc_ff - term) : (acc_ff + term);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // saturate to the result width
   assign acc_wide = {{snpm_pkg::VALUE_W{acc_ff[ACC_W-1]}}, acc_ff};
   always_comb begin
      if (acc_wide > SAT_MAX) begin
         sat_value = snpm_pkg::VALUE_W'(SAT_MAX);
      end else if (acc_wide < SAT_MIN) begin
         sat_value = snpm_pkg::VALUE_W'(SAT_MIN);
      end else begin
         sat_value = acc_wide[snpm_pkg::VALUE_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_index_ff <= k_ff;
         rsp_value_ff <= sat_value;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_value     = rsp_value_ff;

   assign sts.last_term = cnt_ff == LAST;
   assign sts.pipe_busy = s1_vld_ff || s2_vld_ff;
   assign sts.out_busy  = rsp_valid_ff && !rsp_tready;

endmodule

[sv/sparse_negacyclic_poly_multiply_core.sv]
// Negated sparse negacyclic product, one coefficient per compute word. Load words
// (req_tuser 0: challenge position into a slot, 1: dense coefficient) are accepted
// whenever the core is idle, even while a result waits on the rsp side. A compute
// word (req_tuser 2) holds the input until the result is loaded, plus any time the
// previous result stays untaken: the term loop reads the position store and then
// the dense store once per challenge term through a single read port, and the
// accumulator and output registers follow the last read. Sums are saturated to 29
// bits; an index at or above RING_DEGREE returns zero. Stores have no reset: write
// every entry a compute will touch before issuing it.
module sparse_negacyclic_poly_multiply_core #(
   parameter int RING_DEGREE      = snpm_pkg::RING_DEGREE_DEF,
   parameter int CHALLENGE_WEIGHT = snpm_pkg::CHALLENGE_WEIGHT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // slot[4:0], position[13:5], coeff_index[22:14], coeff_value[46:23], zero[47]
   input  logic [snpm_pkg::REQ_DATA_W-1:0]       req_tdata,
   // operation[1:0]
   input  logic [snpm_pkg::OP_W-1:0]             req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_index[8:0], out_value[37:9], zero[39:38]
   output logic [snpm_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   snpm_pkg::cmd_type cmd;
   snpm_pkg::sts_type sts;

   logic [snpm_pkg::INDEX_W-1:0]        rsp_index;
   logic signed [snpm_pkg::VALUE_W-1:0] rsp_value;

   snpm_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   snpm_datapath #(
      .RING_DEGREE      (RING_DEGREE),
      .CHALLENGE_WEIGHT (CHALLENGE_WEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_tuser),
      .req_slot        (req_tdata[4:0]),
      .req_position    (req_tdata[13:5]),
      .req_coeff_index (req_tdata[22:14]),
      .req_coeff_value (req_tdata[46:23]),
      .rsp_tready      (rsp_tready),
      .sts             (sts),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_index       (rsp_index),
      .rsp_value       (rsp_value)
   );

   // pack result word
   assign rsp_tdata = {2'b00, rsp_value, rsp_index};

endmodule

[sv/snpm_checker.sv]
module snpm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [snpm_pkg::OP_W-1:0]          req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [snpm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // a compute word closes the input side for the term loop
   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == snpm_pkg::OP_COMPUTE) |=> !req_tready)
      else $error("input accepted during a compute");

   // a new result only comes out of a compute, never from the idle state
   a_rsp_from_compute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a compute");

   // pad bits of the result word stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:38] == 2'b00))
      else $error("result pad bits set");

endmodule

bind sparse_negacyclic_poly_multiply_core snpm_checker u_snpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
